// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the stable sorted priority queue
// Entry layout, command and status codes, and the control bundle for the cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int ITEM_W = 32;
    localparam int PRIO_W = 16;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;

    // command codes carried in s_tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // status codes carried in m_tuser
    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic signed [ITEM_W-1:0] item;
    } entry_t;

    // shift controls broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctl_t;

    typedef struct packed {
        logic [OCC_W-1:0]         occ;
        logic signed [PRIO_W-1:0] prio;
        logic signed [ITEM_W-1:0] item;
        logic [STAT_W-1:0]        status;
    } result_t;

endpackage

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on insert it keeps, takes the new entry or takes the left
// neighbor's entry; on delete it takes the right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  entry_t    new_entry,
    input  logic      occupied,
    input  logic      left_ahead,
    input  entry_t    left_entry,
    input  entry_t    right_entry,
    output logic      ahead,
    output entry_t    entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // an entry of equal priority stays ahead of the newcomer
    assign ahead = occupied && ($signed(entry_reg.prio) <= $signed(new_entry.prio));

    always_comb begin
        entry_next = entry_reg;
        priority if (ctl.ins) begin
            priority if (ahead) begin
                entry_next = entry_reg;
            end else if (left_ahead) begin
                entry_next = new_entry;
            end else begin
                entry_next = left_entry;
            end
        end else if (ctl.del) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/stable_sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue: bounded priority queue kept as a sorted chain
// A row of CAPACITY cells keeps entries in ascending priority, arrival order
// among equal priorities, with the front entry in cell 0.
//
// Input channel s_*: s_tuser selects insert (0) or delete (1); s_tdata holds
// the item and its priority. Every input transaction yields one result on
// m_*: m_tuser carries the status (ok, underflow, overflow), m_tdata the
// removed item and priority (zero unless a delete succeeded) and the
// occupancy after the operation.
// Each transaction is applied to the chain in the cycle it is accepted: all
// cells compare against the new priority and shift in that same clock, so
// the queue takes one transaction per cycle while s_tready is high, and the
// result is registered into the output slot, or into the second slot behind a held result.
// A two-deep output buffer lets one more transaction in while a result is
// stalled; with both slots full s_tready drops until m_tready returns.
// Reset (aresetn low at a clock edge) empties the queue and the output
// buffer at once; no clearing pass is needed, cell contents are don't care.
// An insert into a full queue is dropped and reported as overflow.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // item_value[31:0], entry_priority[47:32]
    input  logic [0:0]  s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // removed_item[31:0], removed_priority[47:32],
                                   // occupancy[52:48], zero[55:53]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic          skid_valid_reg;
    result_t       out_reg;
    result_t       skid_reg;
    result_t       res;

    logic      accept;
    logic      is_delete;
    logic      full;
    logic      empty;
    logic      do_ins;
    logic      do_del;
    cell_ctl_t ctl;
    entry_t    new_entry;

    entry_t                entries [CAPACITY];
    logic [CAPACITY-1:0]   ahead;

    // nothing is taken while reset is held
    assign s_tready  = aresetn && !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign is_delete = (s_tuser[0] == CMD_DELETE);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign do_ins    = accept && !is_delete && !full;
    assign do_del    = accept && is_delete && !empty;
    assign ctl.ins   = do_ins;
    assign ctl.del   = do_del;

    assign new_entry.item = $signed(s_tdata[31:0]);
    assign new_entry.prio = $signed(s_tdata[47:32]);

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic   occupied;
            logic   left_ahead;
            entry_t left_entry;
            entry_t right_entry;

            assign occupied = (CW'(i) < count_reg);

            if (i == 0) begin : g_first
                // the front slot has nothing ahead of it
                assign left_ahead = 1'b1;
                assign left_entry = new_entry;
            end else begin : g_inner
                assign left_ahead = ahead[i-1];
                assign left_entry = entries[i-1];
            end

            if (i == CAPACITY - 1) begin : g_last
                assign right_entry = entries[i];
            end else begin : g_body
                assign right_entry = entries[i+1];
            end

            spq_cell u_cell (
                .aclk        (aclk),
                .ctl         (ctl),
                .new_entry   (new_entry),
                .occupied    (occupied),
                .left_ahead  (left_ahead),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .ahead       (ahead[i]),
                .entry       (entries[i])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (do_ins) begin
            count_next = count_reg + CW'(1);
        end else if (do_del) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb begin
        res.status = STATUS_OK;
        res.item   = '0;
        res.prio   = '0;
        res.occ    = OCC_W'(count_next);
        unique case (s_tuser[0])
            CMD_INSERT: begin
                if (full) begin
                    res.status = STATUS_OVERFLOW;
                end
            end
            CMD_DELETE: begin
                if (empty) begin
                    res.status = STATUS_UNDERFLOW;
                end else begin
                    res.item = entries[0].item;
                    res.prio = entries[0].prio;
                end
            end
            default: begin
                res.status = STATUS_OK;
            end
        endcase
    end

    logic pop;
    assign pop = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            priority if (pop) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= accept;
                end
            end else if (accept) begin
                if (out_valid_reg) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        priority if (pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else begin
                out_reg <= res;
            end
        end else if (accept) begin
            if (out_valid_reg) begin
                skid_reg <= res;
            end else begin
                out_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {3'b000, out_reg.occ, out_reg.prio, out_reg.item};

    // count never runs past the chain length
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    // the second buffer slot only fills behind a held result
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full while output slot empty");

    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        do_ins |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the queue");

    a_del_count: assert property (@(posedge aclk) disable iff (!aresetn)
        do_del |=> count_reg == $past(count_reg) - CW'(1))
        else $error("delete did not shrink the queue");

    // a dropped or underflowing command leaves the queue size alone
    a_reject_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !do_ins && !do_del) |=> $stable(count_reg))
        else $error("rejected command changed the queue");

endmodule

// ===== verif/tb_stable_sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_sorted_priority_queue: self-checking bench for the sorted queue
// A queued driver feeds insert and delete transactions, and a scoreboard keeps
// its own sorted list to predict status, removed entry and occupancy. The run
// covers empty deletes, full inserts, priority ties and random back-pressure.
// ----------------------------------------------------------------------------
module tb_stable_sorted_priority_queue;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int RANDOM_OPS    = 1175;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic                     cmd;
        logic signed [ITEM_W-1:0] item;
        logic signed [PRIO_W-1:0] prio;
    } queue_op_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;    // item_value[31:0], entry_priority[47:32]
    logic [0:0]  s_tuser  = '0;    // cmd[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;          // removed_item[31:0], removed_priority[47:32],
                                   // occupancy[52:48], zero[55:53]
    logic [1:0]  m_tuser;          // status[1:0]

    queue_op_t op_backlog[$];
    entry_t    sorted_model[$];
    result_t   expected_results[$];

    int send_idle_pct = 10;
    int recv_idle_pct = 73;
    int accepted_ops  = 0;
    int results_seen  = 0;
    int mismatch_count = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;

    stable_sorted_priority_queue #(
        .CAPACITY (QUEUE_DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    // applies one transaction to the sorted list and returns what the block reports
    function automatic result_t apply_queue_op(logic cmd, logic signed [ITEM_W-1:0] item,
                                               logic signed [PRIO_W-1:0] prio);
        result_t res;
        entry_t  ent;
        int      pos;
        res = '0;
        res.status = STATUS_OK;
        if (cmd == CMD_INSERT) begin
            if (sorted_model.size() >= QUEUE_DEPTH) begin
                res.status = STATUS_OVERFLOW;
            end else begin
                // new entry goes behind every entry of lower or equal priority
                pos = 0;
                while (pos < sorted_model.size() &&
                       $signed(sorted_model[pos].prio) <= $signed(prio))
                    pos++;
                ent.item = item;
                ent.prio = prio;
                sorted_model.insert(pos, ent);
            end
        end else if (sorted_model.size() == 0) begin
            res.status = STATUS_UNDERFLOW;
        end else begin
            ent = sorted_model.pop_front();
            res.item = ent.item;
            res.prio = ent.prio;
        end
        res.occ = OCC_W'(sorted_model.size());
        return res;
    endfunction

    function automatic logic signed [PRIO_W-1:0] random_priority();
        logic signed [PRIO_W-1:0] p;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: p = PRIO_W'(int'($urandom_range(0, 6)) - 3);
            12, 13, 14, 15, 16:                   p = PRIO_W'($urandom);
            17:                                   p = 16'sh8000;
            18:                                   p = 16'sh7fff;
            default:                              p = -16'sd1;
        endcase
        return p;
    endfunction

    task automatic add_op(logic cmd, logic signed [ITEM_W-1:0] item,
                          logic signed [PRIO_W-1:0] prio);
        queue_op_t op;
        op.cmd  = cmd;
        op.item = item;
        op.prio = prio;
        op_backlog.push_back(op);
    endtask

    // driver: predicts each accepted transaction, then loads the next one
    always @(posedge aclk) begin
        queue_op_t op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_queue_op(s_tuser[0], s_tdata[31:0],
                                                          s_tdata[47:32]));
                accepted_ops++;
            end
            if (!s_tvalid || s_tready) begin
                if (op_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    op = op_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= op.cmd;
                    s_tdata  <= {op.prio, op.item};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transaction against the oldest prediction
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_left > 0)
                hold_left--;
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected result status=%0d data=%h",
                                 $realtime, m_tuser, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser != want.status || m_tdata[31:0] != want.item ||
                        m_tdata[47:32] != want.prio || m_tdata[52:48] != want.occ) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"%0t: result %0d expected status=%0d item=%h prio=%h ",
                                      "occ=%0d, got status=%0d item=%h prio=%h occ=%0d"},
                                     $realtime, results_seen, want.status, want.item,
                                     want.prio, want.occ, m_tuser, m_tdata[31:0],
                                     m_tdata[47:32], m_tdata[52:48]);
                    end
                end
                // long back-pressure so the output buffer fills and input stalls
                if (results_seen == 250 || results_seen == 900)
                    hold_left = HOLD_CYCLES;
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int n;
        int k;
        int run_len;
        int ins_pct;

        // directed: empty delete, extreme fields, ties, fill to full and overflow
        add_op(CMD_DELETE, 32'sh7fffffff, 16'sh7fff);
        add_op(CMD_INSERT, 32'sh11111111, 16'sd5);
        add_op(CMD_INSERT, 32'sh00000000, 16'sh7fff);
        add_op(CMD_INSERT, -32'sd1, 16'sh8000);
        add_op(CMD_INSERT, 32'sh22222222, 16'sd5);
        add_op(CMD_INSERT, 32'sh80000000, 16'sd0);
        add_op(CMD_INSERT, 32'sh7fffffff, -16'sd1);
        add_op(CMD_INSERT, 32'sh33333333, 16'sd5);
        add_op(CMD_INSERT, 32'sh44444444, 16'sh8000);
        add_op(CMD_INSERT, 32'sh55555555, 16'sh7fff);
        for (k = 0; k < 7; k++)
            add_op(CMD_INSERT, ITEM_W'($urandom), PRIO_W'(k % 3 + 4));
        add_op(CMD_INSERT, 32'shdeadbeef, 16'sh8000);
        for (k = 0; k < 7; k++)
            add_op(CMD_DELETE, ITEM_W'($urandom), PRIO_W'($urandom));

        // random runs, each biased toward filling, draining or neither
        n = 0;
        while (n < RANDOM_OPS) begin
            case ($urandom_range(0, 2))
                0:       ins_pct = 85;
                1:       ins_pct = 15;
                default: ins_pct = 50;
            endcase
            run_len = $urandom_range(8, 40);
            for (k = 0; k < run_len && n < RANDOM_OPS; k++) begin
                add_op(($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_DELETE,
                       ITEM_W'($urandom), random_priority());
                n++;
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_ops < 400)
            @(posedge aclk);
        send_idle_pct = 73;
        recv_idle_pct = 10;
        while (accepted_ops < 800)
            @(posedge aclk);
        send_idle_pct = 0;
        recv_idle_pct = 0;

        while (op_backlog.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
